@@ hdl/complete_tree_array_store_unit_defines.svh @@
// Assertion macros shared by the tree store RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef COMPLETE_TREE_ARRAY_STORE_UNIT_DEFINES_SVH
`define COMPLETE_TREE_ARRAY_STORE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define CTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Antecedent implies consequent in the following cycle.
`define CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CTS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/cts_pkg.sv @@
// Package for the tree store: sizes, request codes, state type and helpers.
// No dependencies.
package cts_pkg;

  localparam int CAPACITY = 1024;
  localparam int ELEM_W   = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int REQ_W    = 3;
  localparam int HEIGHT_W = 5;
  localparam int LEAF_W   = 10;

  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_GET    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SET    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FIND   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN
  } state_t;

  // Floor of log2 of the count, or minus one for an empty tree.
  function automatic logic signed [HEIGHT_W-1:0] tree_height(input logic [COUNT_W-1:0] n);
    logic signed [HEIGHT_W-1:0] h;
    h = -5'sd1;
    for (int i = 0; i < COUNT_W; i++) begin
      if (n[i]) begin
        h = HEIGHT_W'(i);
      end
    end
    return h;
  endfunction

  // Number of leaves: count minus half the count, rounded down.
  function automatic logic [LEAF_W-1:0] tree_leaves(input logic [COUNT_W-1:0] n);
    logic [COUNT_W-1:0] d;
    d = n - (n >> 1);
    return d[LEAF_W-1:0];
  endfunction

endpackage

@@ hdl/complete_tree_array_store_unit.sv @@
// Complete binary tree store in level order with element count.
// Insert, set, clear and rejected requests: result registered directly from the transfer.
// Get and remove: one read of the store memory, result in ST_READ and, for remove, a write back.
// Find: one memory read per entry compared against the key in ST_SCAN, until a hit or the last entry.
// A new request is taken once the previous result has left or is leaving the output register.
// Reset clears the state, the count and the result valid flag; store contents stay undefined.
module complete_tree_array_store_unit
  import cts_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [REQ_W-1:0]           in_req_type,
  input  logic [ADDR_W-1:0]          in_slot,
  input  logic [ELEM_W-1:0]          in_item_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_ok,
  output logic [ELEM_W-1:0]          out_read_value,
  output logic [ADDR_W-1:0]          out_found_slot,
  output logic [COUNT_W-1:0]         out_count,
  output logic signed [HEIGHT_W-1:0] out_height,
  output logic [LEAF_W-1:0]          out_leaf_count
);

`include "complete_tree_array_store_unit_defines.svh"

  state_t                      state_r, state_nxt;
  logic [COUNT_W-1:0]          fill_r, fill_nxt;
  logic [ADDR_W-1:0]           slot_r, slot_nxt;
  logic [ELEM_W-1:0]           val_r, val_nxt;
  logic                        rm_r, rm_nxt;
  logic [ADDR_W-1:0]           cmp_r, cmp_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_ok_r;
  logic [ELEM_W-1:0]           out_read_value_r;
  logic [ADDR_W-1:0]           out_found_slot_r;
  logic [COUNT_W-1:0]          out_count_r;
  logic signed [HEIGHT_W-1:0]  out_height_r;
  logic [LEAF_W-1:0]           out_leaf_count_r;

  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [ELEM_W-1:0]           mem_wdata;
  logic [ADDR_W-1:0]           mem_raddr;
  logic [ELEM_W-1:0]           mem_rdata;

  logic                        in_xfer;
  logic                        in_range;
  logic                        full;
  logic                        go_read;
  logic                        go_scan;
  logic                        scan_hit;
  logic                        scan_last;
  logic                        load_out;
  logic                        res_ok;
  logic [ELEM_W-1:0]           res_rd;
  logic [ADDR_W-1:0]           res_found;
  logic [COUNT_W-1:0]          res_fill;

  cts_ram #(
    .WIDTH(ELEM_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_xfer   = in_valid && in_ready;
  assign in_range  = {1'b0, in_slot} < fill_r;
  assign full      = fill_r == COUNT_W'(CAPACITY);
  assign go_read   = in_range && ((in_req_type == REQ_GET) || (in_req_type == REQ_REMOVE));
  assign go_scan   = (in_req_type == REQ_FIND) && (fill_r != '0);
  assign scan_hit  = mem_rdata == val_r;
  assign scan_last = {1'b0, cmp_r} == COUNT_W'(fill_r - 1'b1);

  always_comb begin : next_state
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && go_read) begin
          state_nxt = ST_READ;
        end else if (in_xfer && go_scan) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_hit || scan_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin : datapath
    mem_we    = 1'b0;
    mem_waddr = in_slot;
    mem_wdata = in_item_value;
    mem_raddr = in_slot;
    fill_nxt  = fill_r;
    slot_nxt  = slot_r;
    val_nxt   = val_r;
    rm_nxt    = rm_r;
    cmp_nxt   = cmp_r;
    load_out  = 1'b0;
    res_ok    = 1'b0;
    res_rd    = '0;
    res_found = '0;
    res_fill  = fill_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          slot_nxt = in_slot;
          val_nxt  = in_item_value;
          rm_nxt   = in_req_type == REQ_REMOVE;
          cmp_nxt  = '0;
          case (in_req_type)
            REQ_INSERT: begin
              load_out = 1'b1;
              if (!full) begin
                mem_we    = 1'b1;
                mem_waddr = fill_r[ADDR_W-1:0];
                fill_nxt  = fill_r + 1'b1;
                res_fill  = fill_r + 1'b1;
                res_ok    = 1'b1;
              end
            end
            REQ_REMOVE: begin
              mem_raddr = ADDR_W'(fill_r - 1'b1);
              load_out  = !in_range;
            end
            REQ_GET: begin
              load_out = !in_range;
            end
            REQ_SET: begin
              load_out = 1'b1;
              if (in_range) begin
                mem_we = 1'b1;
                res_ok = 1'b1;
              end
            end
            REQ_FIND: begin
              mem_raddr = '0;
              load_out  = !go_scan;
            end
            REQ_CLEAR: begin
              load_out = 1'b1;
              fill_nxt = '0;
              res_fill = '0;
              res_ok   = 1'b1;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        load_out = 1'b1;
        res_ok   = 1'b1;
        if (rm_r) begin
          mem_we    = 1'b1;
          mem_waddr = slot_r;
          mem_wdata = mem_rdata;
          fill_nxt  = fill_r - 1'b1;
          res_fill  = fill_r - 1'b1;
        end else begin
          res_rd = mem_rdata;
        end
      end
      ST_SCAN: begin
        mem_raddr = cmp_r + 1'b1;
        cmp_nxt   = cmp_r + 1'b1;
        if (scan_hit) begin
          load_out  = 1'b1;
          res_ok    = 1'b1;
          res_found = cmp_r;
        end else if (scan_last) begin
          load_out = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin : out_handshake
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    val_r  <= val_nxt;
    rm_r   <= rm_nxt;
    cmp_r  <= cmp_nxt;
    if (load_out) begin
      out_ok_r         <= res_ok;
      out_read_value_r <= res_rd;
      out_found_slot_r <= res_found;
      out_count_r      <= res_fill;
      out_height_r     <= tree_height(res_fill);
      out_leaf_count_r <= tree_leaves(res_fill);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_read_value_r;
  assign out_found_slot = out_found_slot_r;
  assign out_count      = out_count_r;
  assign out_height     = out_height_r;
  assign out_leaf_count = out_leaf_count_r;

  `CTS_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_r <= COUNT_W'(CAPACITY))
  `CTS_ASSERT_NOW(a_busy_out_empty, clk, rst_n, state_r != ST_IDLE, !out_valid_r)
  `CTS_ASSERT_NOW(a_scan_in_fill, clk, rst_n, state_r == ST_SCAN, {1'b0, cmp_r} < fill_r)
  `CTS_ASSERT_NEXT(a_read_follows, clk, rst_n, in_xfer && go_read, state_r == ST_READ)
  `CTS_ASSERT_NEXT(a_read_result, clk, rst_n, state_r == ST_READ, out_valid_r && out_ok_r)

endmodule

@@ hdl/cts_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module cts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
